// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the thermostat rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

// ----- hw/rtl/thfc_pkg.sv -----
// shared types and constants for the fahrenheit thermostat
package thfc_pkg;

   // field widths
   localparam int RAW_W    = 11;
   localparam int F10_W    = 12;
   localparam int WHOLE_W  = 9;
   localparam int TENTHS_W = 4;
   localparam int LIMIT_W  = 8;
   localparam int CSR_IDX_W = 8;

   // conversion constants
   localparam logic [F10_W-1:0] F10_OFFSET = 12'd320;
   // 6554 / 2^16 approximates one tenth, exact for every f10 this block can see
   localparam int               RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;
   localparam int               RECIP_SHIFT = 16;

   // register reset values
   localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET  = 8'd65;
   localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RESET = 8'd75;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMIT  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LIMIT = 8'd1;

   // saturation point for limit compares
   localparam logic [LIMIT_W-1:0] COMPARE_MAX = 8'd255;

   typedef struct packed {
      logic [LIMIT_W-1:0] low;
      logic [LIMIT_W-1:0] high;
   } limits_type;

   typedef struct packed {
      logic changed;
      logic heater;
      logic cooler;
   } status_type;

endpackage

// ----- hw/rtl/thfc_csr.sv -----
// limit registers written through the csr channel
module thfc_csr
   import thfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata,
   output limits_type           limits
);

   logic [LIMIT_W-1:0] low_ff, low_in;
   logic [LIMIT_W-1:0] high_ff, high_in;

   // decode the write beat, unknown indexes are dropped
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LOW_LIMIT:  low_in  = csr_wdata;
            CSR_HIGH_LIMIT: high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= LOW_LIMIT_RESET;
         high_ff <= HIGH_LIMIT_RESET;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign limits.low  = low_ff;
   assign limits.high = high_ff;

endmodule

// ----- hw/rtl/thfc_conv.sv -----
// celsius sixteenths to fahrenheit whole degrees and tenths
module thfc_conv
   import thfc_pkg::*;
(
   input  logic [RAW_W-1:0]    raw,
   output logic [WHOLE_W-1:0]  whole,
   output logic [TENTHS_W-1:0] tenths
);

   logic [RAW_W+3:0]           times9;
   logic [F10_W-1:0]           f10;
   logic [F10_W+RECIP_W-1:0]   recip_prod;
   logic [F10_W-1:0]           whole_x10;
   logic [F10_W-1:0]           rem;

   // raw * 9 / 8 + 320, in tenths of a degree
   assign times9 = {1'b0, raw, 3'b000} + {4'b0000, raw};
   assign f10    = times9[RAW_W+3:3] + F10_OFFSET;

   // divide by ten through the reciprocal
   assign recip_prod = {{RECIP_W{1'b0}}, f10} * {{F10_W{1'b0}}, RECIP_TEN};
   assign whole      = recip_prod[RECIP_SHIFT+WHOLE_W-1:RECIP_SHIFT];

   // remainder from whole * 10
   assign whole_x10 = {whole, 3'b000} + {2'b00, whole, 1'b0};
   assign rem       = f10 - whole_x10;
   assign tenths    = rem[TENTHS_W-1:0];

endmodule

// ----- hw/rtl/thfc_ctrl.sv -----
// change detect and heat/cool decision with the kept thermostat state
`include "assert_macros.svh"

module thfc_ctrl
   import thfc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [WHOLE_W-1:0]  whole,
   input  logic [TENTHS_W-1:0] tenths,
   input  limits_type          limits,
   output status_type          status
);

   logic [WHOLE_W-1:0]  prev_whole_ff, prev_whole_in;
   logic [TENTHS_W-1:0] prev_tenths_ff, prev_tenths_in;
   logic                heater_ff, heater_in;
   logic                cooler_ff, cooler_in;
   logic [LIMIT_W-1:0]  temp_sat;
   logic                below_low;
   logic                above_high;

   // saturate for the limit compares
   assign temp_sat   = whole[WHOLE_W-1] ? COMPARE_MAX : whole[LIMIT_W-1:0];
   assign below_low  = temp_sat < limits.low;
   assign above_high = temp_sat > limits.high;

   // one action per reading, first match wins
   always_comb begin
      heater_in = heater_ff;
      cooler_in = cooler_ff;
      if (below_low && !heater_ff) begin
         heater_in = 1'b1;
      end else if (!below_low && heater_ff) begin
         heater_in = 1'b0;
      end else if (!above_high && cooler_ff) begin
         cooler_in = 1'b0;
      end else if (above_high && !cooler_ff) begin
         cooler_in = 1'b1;
      end
   end

   assign prev_whole_in  = whole;
   assign prev_tenths_in = tenths;

   assign status.changed = (whole != prev_whole_ff) || (tenths != prev_tenths_ff);
   assign status.heater  = heater_in;
   assign status.cooler  = cooler_in;

   // state moves only when a reading leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_whole_ff  <= '0;
         prev_tenths_ff <= '0;
         heater_ff      <= 1'b0;
         cooler_ff      <= 1'b0;
      end else if (advance) begin
         prev_whole_ff  <= prev_whole_in;
         prev_tenths_ff <= prev_tenths_in;
         heater_ff      <= heater_in;
         cooler_ff      <= cooler_in;
      end
   end

   // checks
   `ASSERT_NEXT(a_hold_when_idle, clock, reset, !advance,
                $stable(heater_ff) && $stable(cooler_ff) && $stable(prev_whole_ff))
   `ASSERT_NEXT(a_heat_on_rule, clock, reset, advance && below_low && !heater_ff,
                heater_ff && $stable(cooler_ff))
   `ASSERT_NEXT(a_single_action, clock, reset, advance,
                !((heater_ff != $past(heater_ff)) && (cooler_ff != $past(cooler_ff))))

endmodule

// ----- hw/rtl/thermostat_fahrenheit_controller.sv -----
// a reading moves from the input register to the result register once that is free;
// throughput: one reading per cycle while rsp_ready does not stall, the conversion
// and decision take a single pass from the input register to the result register
// reset: synchronous, active high; limits return to 65 and 75, heater and cooler
// off, previous reading 0.0, both pipeline stages empty
`include "assert_macros.svh"

module thermostat_fahrenheit_controller
   import thfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [RAW_W-1:0]     req_raw_reading,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WHOLE_W-1:0]   rsp_whole_degrees,
   output logic [TENTHS_W-1:0]  rsp_tenths,
   output logic                 rsp_reading_changed,
   output logic                 rsp_heater_drive,
   output logic                 rsp_cooler_drive,
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata
);

   logic                stage_valid_ff, stage_valid_in;
   logic [RAW_W-1:0]    stage_raw_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WHOLE_W-1:0]  rsp_whole_ff;
   logic [TENTHS_W-1:0] rsp_tenths_ff;
   status_type          rsp_status_ff;
   logic                out_free;
   logic                stage_adv;
   logic                req_take;
   logic [WHOLE_W-1:0]  conv_whole;
   logic [TENTHS_W-1:0] conv_tenths;
   limits_type          limits;
   status_type          status;

   // handshake control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stage_adv = stage_valid_ff && out_free;
   assign req_ready = !stage_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign stage_valid_in = req_take || (stage_valid_ff && !stage_adv);
   assign rsp_valid_in   = stage_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_raw_ff <= req_raw_reading;
      end
   end

   thfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   thfc_conv u_conv (
      .raw    (stage_raw_ff),
      .whole  (conv_whole),
      .tenths (conv_tenths)
   );

   thfc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (stage_adv),
      .whole   (conv_whole),
      .tenths  (conv_tenths),
      .limits  (limits),
      .status  (status)
   );

   // result register
   always_ff @(posedge clock) begin
      if (stage_adv) begin
         rsp_whole_ff  <= conv_whole;
         rsp_tenths_ff <= conv_tenths;
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_whole_degrees   = rsp_whole_ff;
   assign rsp_tenths          = rsp_tenths_ff;
   assign rsp_reading_changed = rsp_status_ff.changed;
   assign rsp_heater_drive    = rsp_status_ff.heater;
   assign rsp_cooler_drive    = rsp_status_ff.cooler;

   // checks
   `ASSERT_NEXT(a_stage_kept, clock, reset, stage_valid_ff && !stage_adv,
                stage_valid_ff && $stable(stage_raw_ff))
   `ASSERT_IMPL(a_tenths_digit, clock, reset, rsp_valid_ff, rsp_tenths_ff <= 4'd9)
   `ASSERT_IMPL(a_whole_floor, clock, reset, rsp_valid_ff, rsp_whole_ff >= 9'd32)

endmodule
